@@ rtl/core/chunk_reassembly_loss_tracker_assert.svh @@
// Assertion macros for the chunk reassembly loss tracker modules; crlt_ctrl uses them.
`ifndef CHUNK_REASSEMBLY_LOSS_TRACKER_ASSERT_SVH
`define CHUNK_REASSEMBLY_LOSS_TRACKER_ASSERT_SVH

// Checks a property at every rising clock edge outside of reset.
`define CRLT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define CRLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/crlt_pkg.sv @@
// Package with the shared types and constants of the chunk reassembly loss tracker.
package crlt_pkg;

    localparam int W_KIND   = 2;
    localparam int W_OFFSET = 18;
    localparam int W_LOST   = 7;
    localparam int W_FRAME  = 6;
    localparam int W_CHUNK  = 7;
    localparam int W_PLEN   = 11;

    localparam int HEADER_BYTES = 16;
    localparam int FULL_PACKET  = 1308;
    localparam logic [W_PLEN-1:0] CHUNK_BYTES_RST = W_PLEN'(FULL_PACKET - HEADER_BYTES);

    localparam logic [W_KIND-1:0] KIND_PLACE    = 2'd0;
    localparam logic [W_KIND-1:0] KIND_LOST     = 2'd1;
    localparam logic [W_KIND-1:0] KIND_COMPLETE = 2'd2;
    localparam logic [W_KIND-1:0] KIND_FAILED   = 2'd3;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_OPEN = 2'd1;
    localparam logic [1:0] PH_SENT = 2'd3;

    typedef struct packed {
        logic load_hdr;
        logic load_list;
        logic emit_place;
        logic emit_lost;
        logic emit_verdict;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic [1:0] phase;
        logic       place_ok;
        logic       do_list;
        logic       pend_now_any;
        logic       pend_any;
        logic       pend_bit;
        logic       pend_last;
        logic       slot_free;
    } t_status;

endpackage

@@ rtl/core/crlt_ctrl.sv @@
// Controller state machine that sequences header, lost list and verdict results.
`include "chunk_reassembly_loss_tracker_assert.svh"

module crlt_ctrl
    import crlt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_op,
    input  t_status i_sts,
    output t_cmd    o_cmd,
    output logic    o_stall
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_PLACE   = 2'd1;
    localparam logic [1:0] S_LIST    = 2'd2;
    localparam logic [1:0] S_VERDICT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (!i_op) begin
                        o_cmd.load_hdr = 1'b1;
                        n_state        = S_PLACE;
                    end else if (i_sts.phase == PH_SENT) begin
                        n_state = S_VERDICT;
                    end else if (i_sts.phase == PH_OPEN) begin
                        o_cmd.load_list = 1'b1;
                        if (i_sts.pend_now_any) begin
                            n_state = S_LIST;
                        end
                    end
                end
            end
            S_PLACE: begin
                if (i_sts.place_ok) begin
                    if (i_sts.slot_free) begin
                        o_cmd.emit_place = 1'b1;
                        o_cmd.load_list  = i_sts.do_list;
                        n_state = (i_sts.do_list && i_sts.pend_now_any) ? S_LIST : S_IDLE;
                    end
                end else begin
                    o_cmd.load_list = i_sts.do_list;
                    n_state = (i_sts.do_list && i_sts.pend_now_any) ? S_LIST : S_IDLE;
                end
            end
            S_LIST: begin
                if (i_sts.pend_bit) begin
                    if (i_sts.slot_free) begin
                        o_cmd.emit_lost = 1'b1;
                        if (i_sts.pend_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_VERDICT: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit_verdict = 1'b1;
                    n_state            = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    `CRLT_ASSERT(a_one_emit, i_clk, i_rst_n, $onehot0({o_cmd.emit_place, o_cmd.emit_lost, o_cmd.emit_verdict}), "more than one result emitted in a cycle")
    `CRLT_ASSERT(a_emit_slot, i_clk, i_rst_n, (o_cmd.emit_place || o_cmd.emit_lost || o_cmd.emit_verdict) |-> i_sts.slot_free, "result emitted while the output slot is busy")
    `CRLT_ASSERT(a_list_pending, i_clk, i_rst_n, (r_state == S_LIST) |-> i_sts.pend_any, "lost list walk with no missing chunk left")
    `CRLT_ASSERT(a_list_sets_sent, i_clk, i_rst_n, o_cmd.load_list |=> (i_sts.phase == PH_SENT), "lost list start did not mark the list as sent")

endmodule

@@ rtl/core/crlt_datapath.sv @@
// Datapath with frame tracking state, offset calculation, lost walk and output register.
module crlt_datapath
    import crlt_pkg::*;
#(
    parameter int MAX_CHUNKS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_sts,
    input  logic                 i_start_flag,
    input  logic                 i_end_flag,
    input  logic [W_FRAME-1:0]   i_frame_num,
    input  logic [W_CHUNK-1:0]   i_chunk_index,
    input  logic [W_CHUNK-1:0]   i_chunk_count,
    input  logic [W_PLEN-1:0]    i_payload_length,
    input  logic [63:0]          i_map_high,
    input  logic [7:0]           i_map_low,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [W_KIND-1:0]    o_kind,
    output logic [W_OFFSET-1:0]  o_write_offset,
    output logic                 o_buffer_select,
    output logic [W_LOST-1:0]    o_lost_chunk,
    output logic [W_FRAME-1:0]   o_cur_frame,
    output logic                 o_last
);

    localparam int JW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam logic [W_CHUNK-1:0] MAX_C = W_CHUNK'(MAX_CHUNKS);

    logic [1:0]            r_phase;
    logic [W_FRAME-1:0]    r_cur;
    logic [W_CHUNK-1:0]    r_chunks;
    logic [W_PLEN-1:0]     r_bytes;
    logic [W_OFFSET-1:0]   r_off;
    logic [MAX_CHUNKS-1:0] r_map;
    logic                  r_ping;
    logic [MAX_CHUNKS-1:0] r_pend;
    logic [JW-1:0]         r_j;
    logic                  r_place_ok;
    logic                  r_do_list;

    // Header update.
    logic                  opening;
    logic [1:0]            n_phase;
    logic [W_FRAME-1:0]    n_cur;
    logic [W_CHUNK-1:0]    n_chunks;
    logic [W_PLEN-1:0]     n_bytes;
    logic [W_OFFSET-1:0]   n_off;
    logic [MAX_CHUNKS-1:0] n_map;
    logic [MAX_CHUNKS-1:0] mark_vec;
    logic [7:0]            map_byte [9];
    logic                  found;
    logic [3:0]            sel_b;
    logic [7:0]            sel_byte;
    logic [3:0]            run;
    logic [3:0]            byte_dist;
    logic [W_CHUNK-1:0]    base;
    logic [W_CHUNK-1:0]    num;
    logic [W_OFFSET-1:0]   prod;

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            map_byte[b] = i_map_high[8*(7-b) +: 8];
        end
        map_byte[8] = i_map_low;
    end

    always_comb begin
        for (int i = 0; i < MAX_CHUNKS; i++) begin
            mark_vec[i] = (i_chunk_index == W_CHUNK'(i));
        end
    end

    always_comb begin
        found    = 1'b0;
        sel_b    = 4'd0;
        sel_byte = 8'd0;
        for (int k = 8; k >= 0; k--) begin
            if (map_byte[k] != 8'd0) begin
                found    = 1'b1;
                sel_b    = 4'(k);
                sel_byte = map_byte[k];
            end
        end
        run = 4'd8;
        for (int i = 7; i >= 0; i--) begin
            if (!sel_byte[i]) begin
                run = 4'(i);
            end
        end
    end

    always_comb begin
        opening   = (i_start_flag && !i_end_flag) ||
                    (!i_start_flag && (i_frame_num != r_cur));
        n_bytes   = (i_start_flag && !i_end_flag) ? i_payload_length : r_bytes;
        n_phase   = opening ? PH_OPEN : r_phase;
        n_cur     = opening ? i_frame_num : r_cur;
        n_chunks  = opening ? i_chunk_count : r_chunks;
        n_map     = (opening ? '0 : r_map) | mark_vec;
        byte_dist = 4'd8 - sel_b;
        base      = W_CHUNK'({byte_dist, 3'b000}) + W_CHUNK'(run);
        // A map with only its last byte set and bit 0 clear would give minus one.
        num       = (base == '0) ? '0 : base - W_CHUNK'(1);
        prod      = W_OFFSET'(num) * W_OFFSET'(n_bytes);
        if (found) begin
            n_off = prod;
        end else begin
            n_off = opening ? '0 : r_off;
        end
    end

    // Missing chunks inside the walk range.
    logic [W_CHUNK-1:0]    walk_len;
    logic [MAX_CHUNKS-1:0] range_mask;
    logic [MAX_CHUNKS-1:0] pend_now;
    logic [MAX_CHUNKS-1:0] j_onehot;
    logic                  slot_free;

    always_comb begin
        walk_len = (r_chunks < MAX_C) ? r_chunks : MAX_C;
        for (int i = 0; i < MAX_CHUNKS; i++) begin
            range_mask[i] = (W_CHUNK'(i) < walk_len);
            j_onehot[i]   = (r_j == JW'(i));
        end
        pend_now = ~r_map & range_mask;
    end

    assign slot_free = !o_out_valid || !i_out_stall;

    always_comb begin
        o_sts              = '0;
        o_sts.phase        = r_phase;
        o_sts.place_ok     = r_place_ok;
        o_sts.do_list      = r_do_list;
        o_sts.pend_now_any = (pend_now != '0);
        o_sts.pend_any     = (r_pend != '0);
        o_sts.pend_bit     = ((r_pend & j_onehot) != '0);
        o_sts.pend_last    = ((r_pend & ~j_onehot) == '0);
        o_sts.slot_free    = slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_cur      <= '0;
            r_chunks   <= '0;
            r_bytes    <= CHUNK_BYTES_RST;
            r_off      <= '0;
            r_map      <= '0;
            r_ping     <= 1'b0;
            r_pend     <= '0;
            r_j        <= '0;
            r_place_ok <= 1'b0;
            r_do_list  <= 1'b0;
        end else begin
            if (i_cmd.load_hdr) begin
                r_phase    <= n_phase;
                r_cur      <= n_cur;
                r_chunks   <= n_chunks;
                r_bytes    <= n_bytes;
                r_off      <= n_off;
                r_map      <= n_map;
                r_place_ok <= (i_frame_num == n_cur);
                r_do_list  <= i_end_flag && (n_phase == PH_OPEN);
            end
            if (i_cmd.load_list) begin
                r_pend  <= pend_now;
                r_j     <= '0;
                r_phase <= PH_SENT;
            end
            if (i_cmd.emit_lost) begin
                r_pend <= r_pend & ~j_onehot;
            end
            if (i_cmd.emit_lost || i_cmd.step) begin
                r_j <= r_j + JW'(1);
            end
            if (i_cmd.emit_verdict) begin
                r_phase <= PH_IDLE;
                if (pend_now == '0) begin
                    r_ping <= ~r_ping;
                end
            end
        end
    end

    // Output register.
    logic emit_any;
    assign emit_any = i_cmd.emit_place || i_cmd.emit_lost || i_cmd.emit_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (emit_any) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_any) begin
            o_buffer_select <= r_ping;
            o_cur_frame     <= r_cur;
            o_write_offset  <= i_cmd.emit_place ? r_off : '0;
            o_lost_chunk    <= i_cmd.emit_lost ? (W_LOST'(r_j) + W_LOST'(1)) : '0;
            if (i_cmd.emit_place) begin
                o_kind <= KIND_PLACE;
                o_last <= !(r_do_list && (pend_now != '0));
            end else if (i_cmd.emit_lost) begin
                o_kind <= KIND_LOST;
                o_last <= o_sts.pend_last;
            end else begin
                o_kind <= (pend_now == '0) ? KIND_COMPLETE : KIND_FAILED;
                o_last <= 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/chunk_reassembly_loss_tracker.sv @@
// Top level of the chunk reassembly loss tracker: controller plus datapath.
// A packet header's placement goes from the placement state into the output register.
// A lost list walks one chunk per cycle, holding at a missing chunk while the output is busy,
// up to min(chunk count, MAX_CHUNKS). A new header or timeout is taken only once the
// controller is back in idle, after the previous one's results have all been emitted.
// Reset is synchronous and active low; it returns the frame state to idle.
module chunk_reassembly_loss_tracker
    import crlt_pkg::*;
#(
    parameter int MAX_CHUNKS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input channel: one transfer per header or timeout.
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_op,
    input  logic                 i_start_flag,
    input  logic                 i_end_flag,
    input  logic [W_FRAME-1:0]   i_frame_num,
    input  logic [W_CHUNK-1:0]   i_chunk_index,
    input  logic [W_CHUNK-1:0]   i_chunk_count,
    input  logic [W_PLEN-1:0]    i_payload_length,
    input  logic [63:0]          i_map_high,
    input  logic [7:0]           i_map_low,
    // Output channel: one transfer per result.
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [W_KIND-1:0]    o_kind,
    output logic [W_OFFSET-1:0]  o_write_offset,
    output logic                 o_buffer_select,
    output logic [W_LOST-1:0]    o_lost_chunk,
    output logic [W_FRAME-1:0]   o_cur_frame,
    output logic                 o_last
);

    // The controller only takes a new transfer while idle. The datapath updates the
    // frame state in the transfer cycle, then the controller steps through the
    // placement, the lost chunk walk or the verdict, each result going into the
    // output register whenever that register is empty or being drained.
    t_cmd    cmd;
    t_status sts;

    crlt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    crlt_datapath #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_start_flag     (i_start_flag),
        .i_end_flag       (i_end_flag),
        .i_frame_num      (i_frame_num),
        .i_chunk_index    (i_chunk_index),
        .i_chunk_count    (i_chunk_count),
        .i_payload_length (i_payload_length),
        .i_map_high       (i_map_high),
        .i_map_low        (i_map_low),
        .i_out_stall      (i_stall),
        .o_out_valid      (o_valid),
        .o_kind           (o_kind),
        .o_write_offset   (o_write_offset),
        .o_buffer_select  (o_buffer_select),
        .o_lost_chunk     (o_lost_chunk),
        .o_cur_frame      (o_cur_frame),
        .o_last           (o_last)
    );

endmodule
